@@ sv/hcp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hcp_pkg: shared types and constants for the Hill curve probability block
// Pipeline payload structs, register indexes and fixed-point helpers.
// ---------------------------------------------------------------------------
package hcp_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MAX_PROB   = 3'd0;
    localparam logic [2:0] REG_HALF_POINT = 3'd1;
    localparam logic [2:0] REG_SLOPE      = 3'd2;
    localparam logic [2:0] REG_ADJUST_EN  = 3'd3;
    localparam logic [2:0] REG_DET_LIMIT  = 3'd4;
    localparam logic [2:0] REG_SUBSTITUTE = 3'd5;

    localparam int FRAC_BITS = 16;
    localparam int LOG_CELLS = 16;
    localparam int EXP_CELLS = 16;
    localparam int DIV_CELLS = 17;

    // Control flags that travel beside every item.
    typedef struct packed {
        logic valid;
        logic sat;   // result is pmax
        logic zero;  // result is zero
    } ctl_t;

    // One lane of the log2 unit: mantissa in Q1.31, integer part, fraction so far.
    typedef struct packed {
        logic [31:0] m;
        logic [4:0]  top;
        logic [15:0] frac;
    } log_lane_t;

    typedef struct packed {
        logic [15:0] f;   // fraction of the exponent
        logic [5:0]  sh;  // 30 - k
        logic [30:0] m;   // 2^f so far, Q1.30
    } exp_data_t;

    typedef struct packed {
        logic [62:0] den;
        logic [63:0] rem;
        logic [16:0] q;
    } div_data_t;

    // Normalize a positive value so that its top set bit sits at bit 31.
    function automatic log_lane_t log_init(input logic [30:0] x);
        log_lane_t r;
        logic [4:0] top;
        top = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (x[i]) begin
                top = 5'(i);
            end
        end
        r.m    = {1'b0, x} << (5'd31 - top);
        r.top  = top;
        r.frac = '0;
        return r;
    endfunction

    // One squaring step of the log2 fraction: yields one more fraction bit.
    function automatic log_lane_t log_step(input log_lane_t a);
        log_lane_t r;
        logic [63:0] sq;
        logic [32:0] s;
        sq = a.m * a.m;
        s  = sq[63:31];
        r.top = a.top;
        if (s[32]) begin
            r.m    = s[32:1];
            r.frac = {a.frac[14:0], 1'b1};
        end else begin
            r.m    = s[31:0];
            r.frac = {a.frac[14:0], 1'b0};
        end
        return r;
    endfunction

    // Floor square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] vv;
        logic [63:0] res;
        logic [63:0] b;
        vv  = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > vv) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (vv >= res + b) begin
                    vv  = vv - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-j) in Q1.30 by repeated floor square roots starting from 2.0.
    function automatic logic [30:0] exp_const(input int j);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 1; i <= 16; i++) begin
            if (i <= j) begin
                c = isqrt64(c << 30);
            end
        end
        return c[30:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/hill_curve_probability.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hill_curve_probability: Hill dose-response probability
// Maps a signed Q16.16 titer to a Q1.16 probability pmax*P/(1+P).
// ---------------------------------------------------------------------------
// The block takes one titer per transfer and returns one probability per
// transfer, in order. It accepts a new titer in every cycle while input
// ready is high, and each result passes through the pipeline stages:
// one input stage, sixteen log2 squaring cells, two stages for the slope
// product and exponent split, sixteen exp2 product cells, two stages that
// form numerator and divisor, seventeen restoring division cells and the
// output register. A skid register behind the output register lets the
// pipeline keep one more result when the sink stalls, so the input stays
// ready while a result waits; input ready drops only while the skid holds a
// result. Titers below the detection limit are replaced by the substitute
// when adjustment is enabled, and titers at or below zero give pmax.
// Configuration registers must be written only while no transfer is in
// flight; they are sampled by the pipeline stages as items pass.
// ---------------------------------------------------------------------------
module hill_curve_probability (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] titer
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // [16:0] probability, [23:17] zero
);
    import hcp_pkg::*;

    // Configuration registers.
    logic        [16:0] max_prob_reg;
    logic        [30:0] half_reg;
    logic signed [15:0] slope_reg;
    logic               adj_reg;
    logic signed [31:0] limit_reg;
    logic signed [31:0] subst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_prob_reg <= 17'd65536;
            half_reg     <= 31'd65536;
            slope_reg    <= 16'sd256;
            adj_reg      <= 1'b0;
            limit_reg    <= '0;
            subst_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_PROB:   max_prob_reg <= cfg_data[16:0];
                REG_HALF_POINT: half_reg     <= cfg_data[30:0];
                REG_SLOPE:      slope_reg    <= signed'(cfg_data[15:0]);
                REG_ADJUST_EN:  adj_reg      <= cfg_data[0];
                REG_DET_LIMIT:  limit_reg    <= signed'(cfg_data);
                REG_SUBSTITUTE: subst_reg    <= signed'(cfg_data);
                default:        ;
            endcase
        end
    end

    // The whole pipeline advances while the skid register is empty.
    logic pipe_en;
    logic skid_valid_reg;
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // Input stage: substitution, sign check and normalization.
    logic signed [31:0] titer;
    logic signed [31:0] t_sel;
    logic               t_pos;
    ctl_t               in_ctl;

    assign titer = signed'(s_tdata);
    assign t_sel = (adj_reg && (titer < limit_reg)) ? subst_reg : titer;
    assign t_pos = t_sel > 32'sd0;

    always_comb
    begin
        in_ctl.valid = s_tvalid;
        in_ctl.sat   = !t_pos;
        in_ctl.zero  = 1'b0;
    end

    ctl_t      log_ctl [0:LOG_CELLS];
    log_lane_t log_t   [0:LOG_CELLS];
    log_lane_t log_h   [0:LOG_CELLS];

    ctl_t      s0_ctl_reg;
    log_lane_t s0_t_reg;
    log_lane_t s0_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (pipe_en)
        begin
            s0_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_t_reg <= log_init(t_pos ? t_sel[30:0] : 31'd1);
            s0_h_reg <= log_init((half_reg == '0) ? 31'd1 : half_reg);
        end
    end

    assign log_ctl[0] = s0_ctl_reg;
    assign log_t[0]   = s0_t_reg;
    assign log_h[0]   = s0_h_reg;

    // Log2 chain: one fraction bit per cell.
    for (genvar g = 0; g < LOG_CELLS; g++)
    begin : g_log
        hcp_log_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .ctl_in  (log_ctl[g]),
            .lt_in   (log_t[g]),
            .lh_in   (log_h[g]),
            .ctl_out (log_ctl[g+1]),
            .lt_out  (log_t[g+1]),
            .lh_out  (log_h[g+1])
        );
    end

    // Slope product: y = slope * (log2 h - log2 t), Q.24.
    logic signed [21:0] d_diff;
    logic signed [37:0] y_next;
    logic signed [37:0] y_reg;
    ctl_t               e1_ctl_reg;

    assign d_diff = signed'({1'b0, log_h[LOG_CELLS].top, log_h[LOG_CELLS].frac})
                  - signed'({1'b0, log_t[LOG_CELLS].top, log_t[LOG_CELLS].frac});
    assign y_next = 38'(slope_reg) * 38'(d_diff);

    // Exponent split: e rounded to Q.16, range checks, k and fraction.
    logic signed [37:0] y_rnd;
    logic signed [29:0] e_val;
    logic signed [29:0] e_off;
    logic               e_hi;
    logic               e_lo;
    ctl_t               e2_ctl_next;
    exp_data_t          e2_next;
    ctl_t               e2_ctl_reg;
    exp_data_t          e2_reg;

    assign y_rnd = (y_reg + 38'sd128) >>> 8;
    assign e_val = y_rnd[29:0];
    assign e_hi  = e_val >= 30'sd2031616;
    assign e_lo  = e_val < -30'sd2097152;
    assign e_off = e_val + 30'sd2097152;

    always_comb
    begin
        e2_ctl_next.valid = e1_ctl_reg.valid;
        e2_ctl_next.sat   = e1_ctl_reg.sat || e_hi;
        e2_ctl_next.zero  = !e1_ctl_reg.sat && !e_hi && e_lo;
        e2_next.f  = e_off[15:0];
        e2_next.sh = 6'd62 - e_off[21:16];
        e2_next.m  = 31'h4000_0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_ctl_reg <= '0;
            e2_ctl_reg <= '0;
        end
        else if (pipe_en)
        begin
            e1_ctl_reg <= log_ctl[LOG_CELLS];
            e2_ctl_reg <= e2_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            y_reg  <= y_next;
            e2_reg <= e2_next;
        end
    end

    // Exp2 chain: one fraction bit of the exponent per cell.
    ctl_t      exp_ctl [0:EXP_CELLS];
    exp_data_t exp_d   [0:EXP_CELLS];

    assign exp_ctl[0] = e2_ctl_reg;
    assign exp_d[0]   = e2_reg;

    for (genvar g = 0; g < EXP_CELLS; g++)
    begin : g_exp
        hcp_exp_cell #(.J(g + 1)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .ctl_in  (exp_ctl[g]),
            .d_in    (exp_d[g]),
            .ctl_out (exp_ctl[g+1]),
            .d_out   (exp_d[g+1])
        );
    end

    // Divisor m + 2^(30-k) and product pmax*m, then the rounded numerator.
    logic [62:0] den_reg;
    logic [47:0] prod_reg;
    ctl_t        d0_ctl_reg;
    ctl_t        d1_ctl_reg;
    div_data_t   d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_ctl_reg <= '0;
            d1_ctl_reg <= '0;
        end
        else if (pipe_en)
        begin
            d0_ctl_reg <= exp_ctl[EXP_CELLS];
            d1_ctl_reg <= d0_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            den_reg    <= 63'(exp_d[EXP_CELLS].m) + (63'd1 << exp_d[EXP_CELLS].sh);
            prod_reg   <= 48'(max_prob_reg) * 48'(exp_d[EXP_CELLS].m);
            d1_reg.den <= den_reg;
            d1_reg.rem <= 64'(prod_reg) + 64'(den_reg >> 1);
            d1_reg.q   <= '0;
        end
    end

    // Division chain: one quotient bit per cell, most significant first.
    ctl_t      div_ctl [0:DIV_CELLS];
    div_data_t div_d   [0:DIV_CELLS];

    assign div_ctl[0] = d1_ctl_reg;
    assign div_d[0]   = d1_reg;

    for (genvar g = 0; g < DIV_CELLS; g++)
    begin : g_div
        hcp_div_cell #(.I(DIV_CELLS - 1 - g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .ctl_in  (div_ctl[g]),
            .d_in    (div_d[g]),
            .ctl_out (div_ctl[g+1]),
            .d_out   (div_d[g+1])
        );
    end

    // Final selection of the special cases and clamping to pmax.
    ctl_t        last_ctl;
    logic [16:0] last_q;
    logic [16:0] res;

    assign last_ctl = div_ctl[DIV_CELLS];
    assign last_q   = div_d[DIV_CELLS].q;

    always_comb
    begin
        if (last_ctl.sat)
        begin
            res = max_prob_reg;
        end
        else if (last_ctl.zero)
        begin
            res = '0;
        end
        else if (last_q > max_prob_reg)
        begin
            res = max_prob_reg;
        end
        else
        begin
            res = last_q;
        end
    end

    // Output register with a skid register behind it.
    logic        out_valid_reg;
    logic [16:0] out_data_reg;
    logic [16:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_en && last_ctl.valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && last_ctl.valid)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
        else if (m_tready && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    // A result never exceeds the configured maximum probability.
    a_res_le_pmax : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg <= max_prob_reg))
        else $error("probability above pmax");

    // The skid register is only filled while the output register is full.
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data with empty output register");

    // A stalled result is never dropped.
    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("result lost during stall");

    // An item that reaches the end of the pipeline while a result is stalled
    // must land in the skid register.
    a_skid_capture : assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_en && last_ctl.valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result not captured in skid");

endmodule
`default_nettype wire

@@ sv/hcp_log_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hcp_log_cell: one squaring step of the log2 chain
// Produces one fraction bit for the titer lane and the half-point lane.
// ---------------------------------------------------------------------------
module hcp_log_cell (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  hcp_pkg::ctl_t          ctl_in,
    input  hcp_pkg::log_lane_t     lt_in,
    input  hcp_pkg::log_lane_t     lh_in,
    output hcp_pkg::ctl_t          ctl_out,
    output hcp_pkg::log_lane_t     lt_out,
    output hcp_pkg::log_lane_t     lh_out
);
    import hcp_pkg::*;

    ctl_t      ctl_reg;
    log_lane_t lt_reg;
    log_lane_t lh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lt_reg <= log_step(lt_in);
            lh_reg <= log_step(lh_in);
        end
    end

    assign ctl_out = ctl_reg;
    assign lt_out  = lt_reg;
    assign lh_out  = lh_reg;

endmodule
`default_nettype wire

@@ sv/hcp_exp_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hcp_exp_cell: one conditional product of the exp2 chain
// Multiplies by 2^(2^-J) when fraction bit J of the exponent is set.
// ---------------------------------------------------------------------------
module hcp_exp_cell #(
    parameter int J = 1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  hcp_pkg::ctl_t          ctl_in,
    input  hcp_pkg::exp_data_t     d_in,
    output hcp_pkg::ctl_t          ctl_out,
    output hcp_pkg::exp_data_t     d_out
);
    import hcp_pkg::*;

    localparam logic [30:0] C   = exp_const(J);
    localparam int          BIT = FRAC_BITS - J;

    ctl_t        ctl_reg;
    exp_data_t   d_reg;
    exp_data_t   d_next;
    logic [61:0] prod;
    logic [61:0] rnd;

    assign prod = d_in.m * C;
    assign rnd  = prod + 62'(1 << 29);

    always_comb
    begin
        d_next = d_in;
        if (d_in.f[BIT])
        begin
            d_next.m = rnd[60:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign d_out   = d_reg;

endmodule
`default_nettype wire

@@ sv/hcp_div_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hcp_div_cell: one restoring division step
// Decides quotient bit I by comparing the remainder with the shifted divisor.
// ---------------------------------------------------------------------------
module hcp_div_cell #(
    parameter int I = 0
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  hcp_pkg::ctl_t          ctl_in,
    input  hcp_pkg::div_data_t     d_in,
    output hcp_pkg::ctl_t          ctl_out,
    output hcp_pkg::div_data_t     d_out
);
    import hcp_pkg::*;

    ctl_t        ctl_reg;
    div_data_t   d_reg;
    div_data_t   d_next;
    logic        take;

    assign take = (d_in.rem >> I) >= {1'b0, d_in.den};

    always_comb
    begin
        d_next     = d_in;
        d_next.q   = {d_in.q[15:0], take};
        if (take)
        begin
            d_next.rem = d_in.rem - ({1'b0, d_in.den} << I);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign d_out   = d_reg;

endmodule
`default_nettype wire

@@ bench/tb_hill_curve_probability.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb_hill_curve_probability: self-checking bench for the Hill curve block
// Streams titers through the block under several register settings, with
// random idle bursts on both sides but in the last phase. Every result is
// compared with a bit-exact fixed-point prediction.
// ---------------------------------------------------------------------------
module tb_hill_curve_probability;
    timeunit 1ns;
    timeprecision 1ps;

    import hcp_pkg::*;

    // Index 6 lies beyond the register list; the block must ignore it.
    localparam logic [2:0] REG_NONE = 3'd6;
    // Drain margin on top of the pipeline depth.
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    hill_curve_probability uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Local copy of the configuration, updated together with every write.
    logic        [16:0] pmax_reg;
    logic        [30:0] half_reg;
    logic signed [15:0] slope_reg;
    logic               adjust_reg;
    logic signed [31:0] limit_reg;
    logic signed [31:0] subst_reg;

    logic [31:0] titer_queue[$];   // titers waiting to be sent
    logic [16:0] prob_queue[$];    // probabilities expected from the block
    logic [63:0] root_const[1:16]; // 2^(2^-j) in Q1.30
    int          fail_count;
    int          send_gap;
    int          recv_gap;
    logic        idle_on;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 in Q.16: integer part from the top set bit, fraction by squaring.
    function automatic longint log2_q16(input logic [31:0] x);
        int          top;
        logic [63:0] mant;
        logic [15:0] frac;
        top = 31;
        while (top > 0 && !x[top])
            top--;
        mant = 64'(x) << (31 - top);
        frac = '0;
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                mant    = mant >> 1;
            end
        end
        return (longint'(top) << 16) + longint'(frac);
    endfunction

    function automatic logic [16:0] hill_probability(input logic signed [31:0] titer_in);
        longint      t;
        longint      d;
        longint      y;
        longint      e;
        longint      k;
        logic [15:0] f;
        logic [63:0] pm;
        logic [63:0] mant;
        logic [63:0] den;
        logic [63:0] r;
        logic [31:0] h;
        t  = titer_in;
        pm = 64'(pmax_reg);
        h  = (half_reg == 0) ? 32'd1 : 32'(half_reg);
        if (adjust_reg && t < longint'(limit_reg))
            t = subst_reg;
        if (t <= 0)
            return pmax_reg;
        d = log2_q16(h) - log2_q16(t[31:0]);
        y = longint'(slope_reg) * d;
        // Q.24 back to Q.16 with rounding half up.
        e = (y + 128) >>> 8;
        if (e >= (longint'(31) << 16))
            return pmax_reg;
        if (e < -(longint'(32) << 16))
            return '0;
        k    = e >>> 16;
        f    = e[15:0];
        mant = 64'd1 << 30;
        for (int j = 1; j <= 16; j++)
            if (f[16 - j])
                mant = (mant * root_const[j] + (64'd1 << 29)) >> 30;
        den = mant + (64'd1 << (30 - k));
        r   = (pm * mant + den / 2) / den;
        if (r > pm)
            r = pm;
        return r[16:0];
    endfunction

    // Register write on the configuration port; the model follows at once
    // since no titer is in flight while the bench writes.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MAX_PROB:   pmax_reg   = value[16:0];
            REG_HALF_POINT: half_reg   = value[30:0];
            REG_SLOPE:      slope_reg  = value[15:0];
            REG_ADJUST_EN:  adjust_reg = value[0];
            REG_DET_LIMIT:  limit_reg  = value;
            REG_SUBSTITUTE: subst_reg  = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random titer: a third of them near the half point so the curve is exercised,
    // plus full-range noise, small values, non-positive values and values
    // close to the detection limit.
    function automatic logic [31:0] random_titer();
        logic [31:0] base;
        int          sh;
        base = (half_reg == 0) ? 32'd1 : 32'(half_reg);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1, 2:
            begin
                sh = $urandom_range(0, 6);
                if ($urandom_range(0, 1))
                    base = base >> sh;
                else if (base < (32'h7fffffff >> sh))
                    base = base << sh;
                return (base ^ ($urandom & 32'h0000ffff)) & 32'h7fffffff;
            end
            3: return $urandom_range(0, 300);
            4: return -$signed(32'($urandom_range(0, 100000)));
            default: return limit_reg + $signed(32'($urandom_range(0, 40))) - 20;
        endcase
    endfunction

    task automatic run_items(input int n);
        for (int i = 0; i < n; i++)
            titer_queue.push_back(random_titer());
    endtask

    // Wait until every titer has been sent and every result has come back.
    task automatic drain();
        while (titer_queue.size() != 0 || s_tvalid || prob_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: presents queued titers, with random idle bursts while idle_on is
    // set. The prediction is made at the edge where the transfer happens.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                prob_queue.push_back(hill_probability(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (titer_queue.size() != 0)
                begin
                    s_tdata  <= titer_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 3);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in random bursts and checks each result transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (prob_queue.size() == 0)
                begin
                    $display("%0t: result %0d with no expectation", $realtime, m_tdata[16:0]);
                    fail_count++;
                end
                else if (m_tdata[16:0] !== prob_queue[0])
                begin
                    $display("%0t: probability expected %0d actual %0d",
                             $realtime, prob_queue[0], m_tdata[16:0]);
                    fail_count++;
                    void'(prob_queue.pop_front());
                end
                else
                    void'(prob_queue.pop_front());
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                recv_gap <= $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        for (int j = 1; j <= 16; j++)
            root_const[j] = '0;
        root_const[1] = floor_sqrt((64'd1 << 31) << 30);
        for (int j = 2; j <= 16; j++)
            root_const[j] = floor_sqrt(root_const[j - 1] << 30);
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        send_gap   = 0;
        recv_gap   = 0;
        idle_on    = 1'b1;
        fail_count = 0;
        pmax_reg   = 17'd65536;
        half_reg   = 31'd65536;
        slope_reg  = 16'sd256;
        adjust_reg = 1'b0;
        limit_reg  = '0;
        subst_reg  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed titers under the reset settings: field extremes, zero,
        // the half point itself and its neighbors.
        titer_queue = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                        32'h00010000, 32'h0000ffff, 32'h00010001, 32'h00020000,
                        32'h00008000, 32'h55555555, 32'haaaaaaaa, 32'h00000100,
                        32'h01000000, 32'h40000000};
        drain();
        run_items(180);
        drain();

        // Power overflow and underflow: steep slopes both ways, largest pmax.
        write_reg(REG_MAX_PROB, 32'd131071);
        write_reg(REG_SLOPE, 32'h00007fff);
        titer_queue = '{32'h00000001, 32'h7fffffff, 32'h00010000, 32'h00010100};
        run_items(170);
        drain();
        write_reg(REG_SLOPE, 32'hffff8000);
        titer_queue = '{32'h00000001, 32'h7fffffff, 32'h00010000, 32'h0000ff00};
        run_items(170);
        drain();

        // Zero slope gives half of pmax; zero half point is treated as one.
        write_reg(REG_SLOPE, 32'h0);
        write_reg(REG_HALF_POINT, 32'h0);
        write_reg(REG_MAX_PROB, 32'd1);
        titer_queue = '{32'h00000001, 32'h7fffffff, 32'h00000002};
        run_items(150);
        drain();

        // Pmax of zero, largest half point, gentle negative slope; an
        // out-of-range index must leave everything as it is.
        write_reg(REG_MAX_PROB, 32'h0);
        write_reg(REG_HALF_POINT, 32'hffffffff);
        write_reg(REG_SLOPE, 32'hffffff00);
        write_reg(REG_NONE, 32'hffffffff);
        titer_queue = '{32'h7fffffff, 32'h00000001};
        run_items(120);
        drain();

        // Adjustment on: titers below the limit take the substitute value.
        write_reg(REG_MAX_PROB, 32'd65536);
        write_reg(REG_HALF_POINT, 32'h00030000);
        write_reg(REG_SLOPE, 32'h00000280);
        write_reg(REG_ADJUST_EN, 32'h1);
        write_reg(REG_DET_LIMIT, 32'h00020000);
        write_reg(REG_SUBSTITUTE, 32'h00010000);
        titer_queue = '{32'h0001ffff, 32'h00020000, 32'h80000000};
        run_items(200);
        drain();

        // Negative substitute forces pmax; extreme limit catches everything
        // but the largest titer.
        write_reg(REG_DET_LIMIT, 32'h7fffffff);
        write_reg(REG_SUBSTITUTE, 32'h80000000);
        titer_queue = '{32'h7fffffff, 32'h7ffffffe};
        run_items(100);
        drain();

        // Final stretch with random settings and no idling on either side.
        write_reg(REG_DET_LIMIT, 32'h80000000);
        write_reg(REG_SUBSTITUTE, $urandom);
        write_reg(REG_ADJUST_EN, 32'h0);
        write_reg(REG_SLOPE, $urandom_range(0, 2048) - 1024);
        write_reg(REG_HALF_POINT, $urandom_range(1, 32'h00ffffff));
        write_reg(REG_MAX_PROB, $urandom_range(0, 65536));
        idle_on = 1'b0;
        run_items(330);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
sv/hcp_pkg.sv
sv/hcp_log_cell.sv
sv/hcp_exp_cell.sv
sv/hcp_div_cell.sv
sv/hill_curve_probability.sv
bench/tb_hill_curve_probability.sv
